/* hdl/pdsd_pkg.sv */
package pdsd_pkg;

  localparam int unsigned DateW  = 16;
  localparam int unsigned YearW  = 7;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;

  localparam logic [MonthW-1:0] MonJan = 4'd1;
  localparam logic [MonthW-1:0] MonFeb = 4'd2;
  localparam logic [MonthW-1:0] MonMar = 4'd3;
  localparam logic [MonthW-1:0] MonMay = 4'd5;
  localparam logic [MonthW-1:0] MonJul = 4'd7;
  localparam logic [MonthW-1:0] MonOct = 4'd10;
  localparam logic [MonthW-1:0] MonDec = 4'd12;

  localparam logic [DayW-1:0] DaysFebShort = 5'd28;
  localparam logic [DayW-1:0] DaysFebLeap  = 5'd29;
  localparam logic [DayW-1:0] DaysShort    = 5'd30;
  localparam logic [DayW-1:0] DaysLong     = 5'd31;

  localparam logic [DateW-1:0] FirstJan1980 = 16'h0021;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
    logic [DateW-1:0]  rem;
  } walk_t;

  typedef struct packed {
    walk_t next;
    logic  clamp;
  } step_t;

  // offset from 1980 divisible by 4 is the same as offset from 1900 divisible by 4
  function automatic logic is_leap(input logic [YearW-1:0] year);
    return (year[1:0] == 2'b00);
  endfunction

  function automatic logic [DateW-1:0] pack_date(input walk_t w);
    return {w.year, w.month, w.day};
  endfunction

endpackage

/* hdl/packed_date_subtract_days_top.sv */
// at most one month boundary is crossed per cycle by the single step unit; busy stays high meanwhile
// throughput: one word at a time, the next start is taken in the cycle done_o shows
// reset (rst_ni low, asynchronous) returns to idle with busy and done_o low
// done_o marks result_date_o for exactly one cycle; the receiver cannot stall it
module packed_date_subtract_days_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [pdsd_pkg::DateW-1:0] start_date_i,
  input  logic [pdsd_pkg::DateW-1:0] days_back_i,
  output logic                       done_o,
  output logic [pdsd_pkg::DateW-1:0] result_date_o
);

  pdsd_pkg::state_e state_q, state_d;
  pdsd_pkg::walk_t  walk_q, walk_d;
  pdsd_pkg::step_t  step;
  logic                       done_q, done_d;
  logic [pdsd_pkg::DateW-1:0] result_q, result_d;

  pdsd_step u_step (
    .cur_i  (walk_q),
    .step_o (step)
  );

  always_comb begin
    state_d  = state_q;
    walk_d   = walk_q;
    done_d   = 1'b0;
    result_d = result_q;
    case (state_q)
      pdsd_pkg::ST_IDLE: begin
        if (start) begin
          walk_d.year  = start_date_i[15:9];
          walk_d.month = start_date_i[8:5];
          walk_d.day   = start_date_i[4:0];
          walk_d.rem   = days_back_i;
          state_d      = pdsd_pkg::ST_RUN;
        end
      end
      pdsd_pkg::ST_RUN: begin
        if (walk_q.rem == '0) begin
          done_d   = 1'b1;
          result_d = pdsd_pkg::pack_date(walk_q);
          state_d  = pdsd_pkg::ST_IDLE;
        end else if (step.clamp) begin
          done_d   = 1'b1;
          result_d = pdsd_pkg::FirstJan1980;
          state_d  = pdsd_pkg::ST_IDLE;
        end else begin
          walk_d = step.next;
        end
      end
      default: begin
        state_d = pdsd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pdsd_pkg::ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_q   <= walk_d;
    result_q <= result_d;
  end

  assign busy          = (state_q == pdsd_pkg::ST_RUN);
  assign done_o        = done_q;
  assign result_date_o = result_q;

endmodule

/* hdl/pdsd_step.sv */
module pdsd_step (
  input  pdsd_pkg::walk_t cur_i,
  output pdsd_pkg::step_t step_o
);

  logic [pdsd_pkg::DayW-1:0]  take;
  logic [pdsd_pkg::DayW-1:0]  day_left;
  logic [pdsd_pkg::DateW-1:0] rem_left;

  // take as many days as the current month still holds, or all remaining days if fewer
  always_comb begin
    if (cur_i.rem > pdsd_pkg::DateW'(cur_i.day)) begin
      take = cur_i.day;
    end else begin
      take = cur_i.rem[pdsd_pkg::DayW-1:0];
    end
    day_left = cur_i.day - take;
    rem_left = cur_i.rem - pdsd_pkg::DateW'(take);
  end

  always_comb begin
    step_o.next.year  = cur_i.year;
    step_o.next.month = cur_i.month;
    step_o.next.day   = day_left;
    step_o.next.rem   = rem_left;
    step_o.clamp      = 1'b0;
    if (day_left == '0) begin
      case (cur_i.month)
        pdsd_pkg::MonJan: begin
          if (cur_i.year == '0) begin
            step_o.clamp = 1'b1;
          end
          step_o.next.year  = cur_i.year - 1'b1;
          step_o.next.month = pdsd_pkg::MonDec;
          step_o.next.day   = pdsd_pkg::DaysLong;
        end
        pdsd_pkg::MonMar: begin
          step_o.next.month = pdsd_pkg::MonFeb;
          step_o.next.day   = pdsd_pkg::is_leap(cur_i.year) ? pdsd_pkg::DaysFebLeap
                                                            : pdsd_pkg::DaysFebShort;
        end
        pdsd_pkg::MonMay, pdsd_pkg::MonJul, pdsd_pkg::MonOct, pdsd_pkg::MonDec: begin
          step_o.next.month = cur_i.month - 1'b1;
          step_o.next.day   = pdsd_pkg::DaysShort;
        end
        default: begin
          // month 0 wraps to 15, then walks down to 12 with no year change
          step_o.next.month = cur_i.month - 1'b1;
          step_o.next.day   = pdsd_pkg::DaysLong;
        end
      endcase
    end
  end

endmodule

/* hdl/pdsd_checker.sv */
module pdsd_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // an accepted word always starts a walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  // a result only ends a walk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy) && !busy))
    else $error("done without a preceding walk");

  // one result per word, never two in a row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two results in consecutive cycles");

  // a walk never ends without handing out its result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> (busy || done_o))
    else $error("walk ended without a result");

endmodule

bind packed_date_subtract_days_top pdsd_checker u_pdsd_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

/* dv/tb_packed_date_subtract_days_top.sv */
`timescale 1ns / 1ps

module tb_packed_date_subtract_days_top;

  localparam int unsigned BaseYear    = 80;
  localparam int unsigned RandWords   = 345;
  localparam int unsigned DrainCycles = 1600;
  localparam int unsigned CycleLimit  = 4000000;
  localparam int unsigned IdlePct     = 32;

  typedef struct {
    logic [pdsd_pkg::DateW-1:0] from_date;
    logic [pdsd_pkg::DateW-1:0] days;
    logic [pdsd_pkg::DateW-1:0] want;
  } date_req_t;

  class past_date_board;
    date_req_t expected_dates[$];
    int unsigned mismatches;

    function new();
      mismatches = 0;
    endfunction

    // walks back one month per step, clamping at the first of january 1980
    function logic [pdsd_pkg::DateW-1:0] date_days_earlier(
        logic [pdsd_pkg::DateW-1:0] from_date, logic [pdsd_pkg::DateW-1:0] days);
      logic [pdsd_pkg::YearW-1:0]  year;
      logic [pdsd_pkg::MonthW-1:0] month;
      logic [pdsd_pkg::DayW-1:0]   day;
      logic [pdsd_pkg::DateW-1:0]  left;
      logic [pdsd_pkg::DateW-1:0]  take;
      year  = from_date[15:9];
      month = from_date[8:5];
      day   = from_date[4:0];
      left  = days;
      while (left != '0) begin
        take = (left > 16'(day)) ? 16'(day) : left;
        day  = day - take[pdsd_pkg::DayW-1:0];
        left = left - take;
        if (day == '0) begin
          case (month)
            pdsd_pkg::MonJan: begin
              if (year == '0) return pdsd_pkg::FirstJan1980;
              year  = year - 1'b1;
              month = pdsd_pkg::MonDec;
              day   = pdsd_pkg::DaysLong;
            end
            pdsd_pkg::MonMar: begin
              month = pdsd_pkg::MonFeb;
              day   = (((year + BaseYear) % 4) != 0) ? pdsd_pkg::DaysFebShort
                                                     : pdsd_pkg::DaysFebLeap;
            end
            pdsd_pkg::MonMay, pdsd_pkg::MonJul, pdsd_pkg::MonOct, pdsd_pkg::MonDec: begin
              month = month - 1'b1;
              day   = pdsd_pkg::DaysShort;
            end
            // month 0 wraps to 15 in the 4-bit counter
            default: begin
              month = month - 1'b1;
              day   = pdsd_pkg::DaysLong;
            end
          endcase
        end
      end
      return {year, month, day};
    endfunction

    function void note_request(logic [pdsd_pkg::DateW-1:0] from_date,
                               logic [pdsd_pkg::DateW-1:0] days);
      date_req_t req;
      req.from_date = from_date;
      req.days      = days;
      req.want      = date_days_earlier(from_date, days);
      expected_dates.push_back(req);
    endfunction

    function int unsigned pending();
      return expected_dates.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_result(logic [pdsd_pkg::DateW-1:0] got);
      date_req_t req;
      if (expected_dates.size() == 0) begin
        report_mismatch($sformatf("result_date %h with no request waiting", got));
      end else begin
        req = expected_dates.pop_front();
        if (got !== req.want)
          report_mismatch($sformatf("date %h minus %0d days: got %h, want %h",
                                    req.from_date, req.days, got, req.want));
      end
    endtask
  endclass

  logic                       clk_i;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic [pdsd_pkg::DateW-1:0] start_date_i;
  logic [pdsd_pkg::DateW-1:0] days_back_i;
  logic                       done_o;
  logic [pdsd_pkg::DateW-1:0] result_date_o;

  past_date_board board;
  int unsigned    cycle_count = 0;
  bit             calm;

  packed_date_subtract_days_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .start_date_i  (start_date_i),
    .days_back_i   (days_back_i),
    .done_o        (done_o),
    .result_date_o (result_date_o)
  );

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) board.check_result(result_date_o);
  end

  function automatic logic [pdsd_pkg::DateW-1:0] make_date(int unsigned year,
                                                           int unsigned month,
                                                           int unsigned day);
    return {year[pdsd_pkg::YearW-1:0], month[pdsd_pkg::MonthW-1:0],
            day[pdsd_pkg::DayW-1:0]};
  endfunction

  function automatic logic [pdsd_pkg::DateW-1:0] rand_valid_date();
    int unsigned year;
    int unsigned month;
    int unsigned last;
    year  = $urandom_range(127, 0);
    month = $urandom_range(12, 1);
    case (month)
      pdsd_pkg::MonFeb:         last = ((year + BaseYear) % 4 == 0) ? 29 : 28;
      4, 6, 9, 11:              last = 30;
      default:                  last = 31;
    endcase
    return make_date(year, month, $urandom_range(last, 1));
  endfunction

  // mostly short spans; long spans walk up to ~1540 months each
  function automatic logic [pdsd_pkg::DateW-1:0] rand_days();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 10) return 16'($urandom_range(40, 0));
    if (pick < 88) return 16'($urandom_range(1000, 0));
    return 16'($urandom_range(65535, 0));
  endfunction

  task send_word(logic [pdsd_pkg::DateW-1:0] from_date, logic [pdsd_pkg::DateW-1:0] days);
    while (!calm && $urandom_range(99) < IdlePct) begin
      @(negedge clk_i);
      start <= 1'b0;
      @(posedge clk_i);
    end
    @(negedge clk_i);
    start        <= 1'b1;
    start_date_i <= from_date;
    days_back_i  <= days;
    do @(posedge clk_i); while (busy);
    board.note_request(from_date, days);
  endtask

  initial begin
    board        = new();
    calm         = 1'b0;
    rst_ni       = 1'b0;
    start        = 1'b0;
    start_date_i = '0;
    days_back_i  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero days keeps even a bogus date
    send_word(pdsd_pkg::FirstJan1980, 16'd0);
    send_word(16'hFFFF, 16'd0);
    send_word(pdsd_pkg::FirstJan1980, 16'd1);
    send_word(pdsd_pkg::FirstJan1980, 16'hFFFF);
    send_word(16'hFFFF, 16'hFFFF);
    send_word(16'h0000, 16'd5);
    send_word(make_date(1980 - 1980, pdsd_pkg::MonJan, 2), 16'd1);
    send_word(make_date(1980 - 1980, pdsd_pkg::MonJan, 2), 16'd2);
    send_word(make_date(1980 - 1980, pdsd_pkg::MonFeb, 1), 16'd31);
    // leap rule over 2000, 2001 and 2100
    send_word(make_date(2000 - 1980, pdsd_pkg::MonMar, 1), 16'd1);
    send_word(make_date(2001 - 1980, pdsd_pkg::MonMar, 1), 16'd1);
    send_word(make_date(2100 - 1980, pdsd_pkg::MonMar, 1), 16'd1);
    send_word(make_date(1985 - 1980, pdsd_pkg::MonJan, 1), 16'd1);
    send_word(make_date(1990 - 1980, pdsd_pkg::MonMay, 1), 16'd1);
    send_word(make_date(1990 - 1980, pdsd_pkg::MonJul, 1), 16'd1);
    send_word(make_date(1990 - 1980, pdsd_pkg::MonOct, 1), 16'd1);
    send_word(make_date(1990 - 1980, pdsd_pkg::MonDec, 1), 16'd1);
    send_word(make_date(1990 - 1980, 8, 1), 16'd1);
    // day zero steps back before counting
    send_word(make_date(5, 6, 0), 16'd1);
    // day past the month length and out-of-range months
    send_word(make_date(12, pdsd_pkg::MonFeb, 31), 16'd40);
    send_word(make_date(10, 0, 5), 16'd10);
    send_word(make_date(10, 15, 3), 16'd100);
    send_word(make_date(10, 13, 31), 16'd70);
    send_word(make_date(127, pdsd_pkg::MonDec, 31), 16'd1);
    send_word(make_date(2050 - 1980, 6, 15), 16'd30000);

    for (int unsigned n = 0; n < RandWords; n++) begin
      calm = (n >= 150 && n < 230);
      if ($urandom_range(99) < 70) send_word(rand_valid_date(), rand_days());
      else send_word(16'($urandom()), rand_days());
    end
    @(negedge clk_i);
    start <= 1'b0;

    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.mismatches == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
